### design/mmn_pkg.sv
package mmn_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int IN_DW  = 24;
  localparam int OUT_DW = 8;

  localparam logic [7:0] UNKNOWN_PEER_RST = 8'hFF;

  // register index taken from paddr[2]
  localparam logic REG_UNKNOWN_PEER = 1'b0;

  typedef enum logic [2:0] {
    FUNC_STATUS  = 3'd0,
    FUNC_DRAIN   = 3'd1,
    FUNC_SET_EN  = 3'd2,
    FUNC_STOPPED = 3'd3,
    FUNC_CANCEL  = 3'd4,
    FUNC_RST_TRK = 3'd5,
    FUNC_READY   = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    NOTE_JOIN    = 2'd0,
    NOTE_LEAVE   = 2'd1,
    NOTE_ENABLED = 2'd2
  } note_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH_EN,
    ST_DRAIN_RD,
    ST_DRAIN_OUT,
    ST_RESP
  } state_t;

endpackage

### design/mmn_ram.sv
module mmn_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/mesh_membership_notifier.sv
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_tvalid/in_tready   | in_tdata: event
// out_    | output    | out_tvalid/out_tready | out_tdata, out_tuser, out_tlast
// cfg_    | input     | APB psel/penable      | unknown_peer_code at byte address 0
//
// One event at a time: status and control events pass through EXEC, then PUSH_EN when
// a second note is queued, then RESP; a drain reads each queued note through DRAIN_RD and
// DRAIN_OUT, using the single read port of the note ring and its registered read data.
// Reset (rst_n, synchronous) empties the ring and clears all tracking state.
// A stalled out_tready holds the sequencer; in_tready is low until it returns to idle.
module mesh_membership_notifier
  import mmn_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [2:0] func, [3] mesh_is_active, [11:4] node_id, [12] link_lost,
  // [20:13] peers, [21] enable_value, [23:22] zero
  input  logic [IN_DW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] mesh_active, [2:1] note_kind, [7:3] zero
  output logic [OUT_DW-1:0] out_tdata,
  // [0] has_note
  output logic              out_tuser,
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  state_t           state_r, state_nxt;
  logic             intent_r, intent_nxt;
  logic             pending_r, pending_nxt;
  logic             seen_r, seen_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic             active_r, active_nxt;
  logic             sent_r, sent_nxt;
  logic [7:0]       unk_r;

  func_t            fn_r;
  logic             mia_r, lost_r, env_r;
  logic [7:0]       node_r, peers_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_mesh_r, out_mesh_nxt;
  logic             out_has_r, out_has_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic             out_last_r, out_last_nxt;

  logic             push_req;
  note_t            push_kind;
  logic             ram_we, ram_re;
  logic [1:0]       ram_rdata;
  logic             out_free, st_ready, cfg_wr;
  logic [PTR_W-1:0] head_inc;

  mmn_ram #(
    .WIDTH (2),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (push_kind),
    .re    (ram_re),
    .raddr (tail_r),
    .rdata (ram_rdata)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_UNKNOWN_PEER) ? {24'd0, unk_r} : '0;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_kind_r, out_mesh_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

  assign out_free = !out_valid_r || out_tready;
  assign st_ready = mia_r && (node_r != 8'd0);
  assign head_inc = next_ptr(head_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unk_r <= UNKNOWN_PEER_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_UNKNOWN_PEER) begin
      unk_r <= cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      fn_r    <= func_t'(in_tdata[2:0]);
      mia_r   <= in_tdata[3];
      node_r  <= in_tdata[11:4];
      lost_r  <= in_tdata[12];
      peers_r <= in_tdata[20:13];
      env_r   <= in_tdata[21];
    end
  end

  always_ff @(posedge clk) begin
    out_mesh_r <= out_mesh_nxt;
    out_has_r  <= out_has_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      intent_r    <= 1'b0;
      pending_r   <= 1'b0;
      seen_r      <= 1'b0;
      prev_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      active_r    <= 1'b0;
      sent_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      intent_r    <= intent_nxt;
      pending_r   <= pending_nxt;
      seen_r      <= seen_nxt;
      prev_r      <= prev_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      active_r    <= active_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    intent_nxt    = intent_r;
    pending_nxt   = pending_r;
    seen_nxt      = seen_r;
    prev_nxt      = prev_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    active_nxt    = active_r;
    sent_nxt      = sent_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_mesh_nxt  = out_mesh_r;
    out_has_nxt   = out_has_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    push_req      = 1'b0;
    push_kind     = NOTE_JOIN;
    ram_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
        case (fn_r)
          FUNC_STATUS: begin
            if (!intent_r || !st_ready || lost_r || peers_r == unk_r) begin
              seen_nxt = 1'b0;
              prev_nxt = '0;
            end else if (!seen_r) begin
              seen_nxt = 1'b1;
              prev_nxt = peers_r;
            end else begin
              if (peers_r > prev_r) begin
                push_req  = 1'b1;
                push_kind = NOTE_JOIN;
              end else if (peers_r < prev_r) begin
                push_req  = 1'b1;
                push_kind = NOTE_LEAVE;
              end
              prev_nxt = peers_r;
            end
            active_nxt = intent_r && st_ready;
            if (intent_r && st_ready && pending_r) begin
              pending_nxt = 1'b0;
              if (push_req) begin
                state_nxt = ST_PUSH_EN;
              end else begin
                push_req  = 1'b1;
                push_kind = NOTE_ENABLED;
              end
            end
          end
          FUNC_DRAIN: begin
            if (intent_r) begin
              sent_nxt  = 1'b0;
              state_nxt = ST_DRAIN_RD;
            end else begin
              head_nxt = '0;
              tail_nxt = '0;
            end
          end
          FUNC_SET_EN: begin
            intent_nxt  = env_r;
            pending_nxt = env_r;
            head_nxt    = '0;
            tail_nxt    = '0;
            if (!env_r) begin
              seen_nxt   = 1'b0;
              prev_nxt   = '0;
              active_nxt = 1'b0;
            end
          end
          FUNC_STOPPED: begin
            active_nxt  = 1'b0;
            pending_nxt = 1'b0;
            seen_nxt    = 1'b0;
            prev_nxt    = '0;
            head_nxt    = '0;
            tail_nxt    = '0;
          end
          FUNC_CANCEL: begin
            pending_nxt = 1'b0;
          end
          FUNC_RST_TRK: begin
            seen_nxt = 1'b0;
            prev_nxt = '0;
            head_nxt = '0;
            tail_nxt = '0;
          end
          FUNC_READY: begin
            if (!intent_r) begin
              active_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      ST_PUSH_EN: begin
        push_req  = 1'b1;
        push_kind = NOTE_ENABLED;
        state_nxt = ST_RESP;
      end
      ST_DRAIN_RD: begin
        if (tail_r == head_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          state_nxt = sent_r ? ST_IDLE : ST_RESP;
        end else begin
          ram_re    = 1'b1;
          tail_nxt  = next_ptr(tail_r);
          state_nxt = ST_DRAIN_OUT;
        end
      end
      ST_DRAIN_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mesh_nxt  = active_r;
          out_has_nxt   = 1'b1;
          out_kind_nxt  = ram_rdata;
          out_last_nxt  = (tail_r == head_r);
          sent_nxt      = 1'b1;
          state_nxt     = ST_DRAIN_RD;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mesh_nxt  = active_r;
          out_has_nxt   = 1'b0;
          out_kind_nxt  = NOTE_JOIN;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    ram_we = push_req;
    if (push_req) begin
      head_nxt = head_inc;
      if (head_inc == tail_r) begin
        tail_nxt = next_ptr(tail_r);
      end
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= PTR_LAST && tail_r <= PTR_LAST)
    else $error("ring pointer out of range");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN_RD && tail_r == head_r |=> head_r == '0 && tail_r == '0)
    else $error("ring not emptied at end of drain");

  a_note_needs_intent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN_RD || state_r == ST_DRAIN_OUT) |-> intent_r)
    else $error("notes drained with intent disabled");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_EXEC || state_r == ST_PUSH_EN)
    else $error("ring write outside push states");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_has_r |-> out_kind_r <= NOTE_ENABLED)
    else $error("illegal note kind");

endmodule
